@@ rtl/length_prefix_deframer_assert.svh @@
// Assertion macros for the length prefix deframer.
// Included by the top level; no other dependencies.
`ifndef LENGTH_PREFIX_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIX_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpd assertion failed");

// Next-cycle implication, disabled during reset.
`define LPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpd assertion failed");

`endif

@@ rtl/lpd_pkg.sv @@
// Shared constants and types for the length prefix deframer.
// No dependencies.
`default_nettype none
package lpd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned HDR_CNT_W    = 3;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned DATA_W       = 32;

  localparam logic [LEN_W-1:0] MTU_RESET   = '1;
  localparam logic [LEN_W-1:0] LIMIT_RESET = '1;

  typedef enum logic [1:0] {
    REG_MTU        = 2'd0,
    REG_LIMIT      = 2'd1,
    REG_BIG_ENDIAN = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

@@ rtl/lpd_if.sv @@
// Valid/ready channel interfaces for the deframer input and result streams.
// Depends on lpd_pkg.
`default_nettype none
interface lpd_in_if
  import lpd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpd_out_if
  import lpd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              data_valid;
  logic              packet_end;
  logic [LEN_W-1:0]  delivered_length;
  logic              oversize_error;

  modport source (output valid, output data_byte, output data_valid, output packet_end,
                  output delivered_length, output oversize_error, input ready);
  modport sink (input valid, input data_byte, input data_valid, input packet_end,
                input delivered_length, input oversize_error, output ready);
endinterface
`default_nettype wire

@@ rtl/length_prefix_deframer.sv @@
// Length prefix deframer: splits a byte stream into length-prefixed frames.
// Depends on lpd_pkg, lpd_if and length_prefix_deframer_assert.svh.
//
// Usage:
//   rx  - one stream byte per item. Each frame is a 4-byte length header
//         (byte order set by header_big_endian) followed by that many bytes.
//   tx  - at most one result item per input byte: payload bytes as they
//         arrive (up to user_buffer_limit per frame), packet_end with the
//         delivered length on the last byte or on an empty frame's header,
//         or a single oversize_error item after which all input is consumed
//         and dropped until reset.
//   APB - registers max_transfer_unit (0x0), user_buffer_limit (0x4),
//         header_big_endian (0x8). Write only while the block is idle.
// A result is registered at the edge that accepts its byte and is on tx in the following cycle.
// Throughput: one byte per cycle while tx is not stalled; the state update is
//   counter compares and a header shift between the accept edge and the tx register.
// Reset (rst, synchronous) clears frame state, the sticky error and tx
//   valid, and restores register defaults.
// When tx stalls, the held result blocks rx until tx takes it;
//   rx.ready = !tx.valid || tx.ready.
`default_nettype none
`include "length_prefix_deframer_assert.svh"
module length_prefix_deframer
  import lpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  lpd_in_if.sink                 rx,
  lpd_out_if.source              tx,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [LEN_W-1:0]     max_transfer_unit;
  logic [LEN_W-1:0]     user_buffer_limit;
  logic                 header_big_endian;

  logic [HDR_CNT_W-1:0] header_bytes_seen, header_bytes_seen_next;
  logic [LEN_W-1:0]     frame_length, frame_length_next;
  logic [LEN_W-1:0]     payload_count, payload_count_next;
  logic                 stuck_error, stuck_error_next;

  logic                 res_valid;
  logic [BYTE_W-1:0]    res_byte;
  logic                 res_data_valid;
  logic                 res_end;
  logic [LEN_W-1:0]     res_len;
  logic                 res_err;

  logic                 rx_acc;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  logic [LEN_W-1:0]     hdr_len;
  logic [LEN_W-1:0]     cnt_inc;
  logic                 deliver;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_transfer_unit <= MTU_RESET;
      user_buffer_limit <= LIMIT_RESET;
      header_big_endian <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MTU:        max_transfer_unit <= pwdata;
        REG_LIMIT:      user_buffer_limit <= pwdata;
        REG_BIG_ENDIAN: header_big_endian <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MTU:        prdata = max_transfer_unit;
      REG_LIMIT:      prdata = user_buffer_limit;
      REG_BIG_ENDIAN: prdata = {{(DATA_W-1){1'b0}}, header_big_endian};
      default:        prdata = '0;
    endcase
  end

  assign rx.ready = !tx.valid || tx.ready;
  assign rx_acc   = rx.valid && rx.ready;

  // header assembly and payload count
  always_comb begin
    if (header_big_endian) begin
      hdr_len = {frame_length[LEN_W-BYTE_W-1:0], rx.rx_byte};
    end else begin
      hdr_len = frame_length |
                (LEN_W'(rx.rx_byte) << {header_bytes_seen[1:0], 3'b000});
    end
    cnt_inc = payload_count + LEN_W'(1);
    deliver = payload_count < user_buffer_limit;
  end

  always_comb begin
    header_bytes_seen_next = header_bytes_seen;
    frame_length_next      = frame_length;
    payload_count_next     = payload_count;
    stuck_error_next       = stuck_error;
    res_valid              = 1'b0;
    res_byte               = '0;
    res_data_valid         = 1'b0;
    res_end                = 1'b0;
    res_len                = '0;
    res_err                = 1'b0;
    if (!stuck_error) begin
      if (header_bytes_seen < HDR_CNT_W'(HEADER_BYTES)) begin
        frame_length_next      = hdr_len;
        header_bytes_seen_next = header_bytes_seen + HDR_CNT_W'(1);
        if (header_bytes_seen == HDR_CNT_W'(HEADER_BYTES - 1)) begin
          payload_count_next = '0;
          if (hdr_len > max_transfer_unit) begin
            stuck_error_next = 1'b1;
            res_valid        = 1'b1;
            res_err          = 1'b1;
          end else if (hdr_len == '0) begin
            header_bytes_seen_next = '0;
            res_valid              = 1'b1;
            res_end                = 1'b1;
          end
        end
      end else begin
        payload_count_next = cnt_inc;
        if (cnt_inc == frame_length) begin
          res_valid              = 1'b1;
          res_byte               = deliver ? rx.rx_byte : '0;
          res_data_valid         = deliver;
          res_end                = 1'b1;
          res_len                = (frame_length < user_buffer_limit) ?
                                   frame_length : user_buffer_limit;
          header_bytes_seen_next = '0;
          frame_length_next      = '0;
          payload_count_next     = '0;
        end else if (deliver) begin
          res_valid      = 1'b1;
          res_byte       = rx.rx_byte;
          res_data_valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes_seen <= '0;
      frame_length      <= '0;
      payload_count     <= '0;
      stuck_error       <= 1'b0;
    end else if (rx_acc) begin
      header_bytes_seen <= header_bytes_seen_next;
      frame_length      <= frame_length_next;
      payload_count     <= payload_count_next;
      stuck_error       <= stuck_error_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (rx_acc) begin
      tx.valid <= res_valid;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_acc && res_valid) begin
      tx.data_byte        <= res_byte;
      tx.data_valid       <= res_data_valid;
      tx.packet_end       <= res_end;
      tx.delivered_length <= res_len;
      tx.oversize_error   <= res_err;
    end
  end

  `LPD_ASSERT_NEXT(a_stuck_silent, clk, rst, stuck_error && !tx.valid, !tx.valid)
  `LPD_ASSERT_NOW(a_err_alone, clk, rst, tx.valid && tx.oversize_error,
                  !tx.data_valid && !tx.packet_end)
  `LPD_ASSERT_NOW(a_hdr_range, clk, rst, 1'b1,
                  header_bytes_seen <= HDR_CNT_W'(HEADER_BYTES))
  `LPD_ASSERT_NOW(a_count_bound, clk, rst,
                  header_bytes_seen == HDR_CNT_W'(HEADER_BYTES),
                  payload_count < frame_length)

endmodule
`default_nettype wire
